FILE: sv/cbc_pkg.sv
// ----------------------------------------------------------------------------
// cbc_pkg
// Types and codes shared by the cartridge bank controller modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cbc_pkg;

   // Result target codes.
   localparam logic [2:0] TGT_ROM_READ  = 3'd0;
   localparam logic [2:0] TGT_RAM_READ  = 3'd1;
   localparam logic [2:0] TGT_RAM_WRITE = 3'd2;
   localparam logic [2:0] TGT_OPEN_BUS  = 3'd3;
   localparam logic [2:0] TGT_REG_WRITE = 3'd4;
   localparam logic [2:0] TGT_INVALID   = 3'd5;

   // Configuration register indexes.
   localparam logic [1:0] CSR_HAS_RAM        = 2'd0;
   localparam logic [1:0] CSR_ROM_COUNT_LOG2 = 2'd1;
   localparam logic [1:0] CSR_RAM_COUNT      = 2'd2;

   // Bus address regions, taken from address bits 15:13.
   localparam logic [2:0] RGN_RAM_ENABLE = 3'b000;
   localparam logic [2:0] RGN_LOWER_BANK = 3'b001;
   localparam logic [2:0] RGN_UPPER_BANK = 3'b010;
   localparam logic [2:0] RGN_MODE       = 3'b011;
   localparam logic [2:0] RGN_EXT_RAM    = 3'b101;

   localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

   typedef struct packed {
      logic        is_write;
      logic [15:0] address;
      logic [7:0]  data;
   } cbc_access_type;

   typedef struct packed {
      logic       has_ram;
      logic       ram_enable;
      logic [6:0] rom_bank;
      logic [1:0] ram_bank;
   } cbc_state_type;

   typedef struct packed {
      logic [2:0]  target;
      logic [20:0] physical_address;
      logic [7:0]  ram_write_data;
   } cbc_result_type;

endpackage

`default_nettype wire

FILE: sv/cbc_bank_regs.sv
// ----------------------------------------------------------------------------
// cbc_bank_regs
// Configuration and banking registers, updated by register writes on the bus.
// ----------------------------------------------------------------------------
`default_nettype none

module cbc_bank_regs (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_write_enable,
   input  wire logic [1:0]              csr_index,
   input  wire logic [2:0]              csr_write_data,
   input  wire logic                    update,
   input  wire cbc_pkg::cbc_access_type access,
   output cbc_pkg::cbc_state_type       state
);

   logic       has_ram_ff;
   logic [2:0] rom_count_log2_ff;
   logic [2:0] ram_count_ff;
   logic       ram_enable_ff,  ram_enable_in;
   logic [4:0] lower_bank_ff,  lower_bank_in;
   logic [1:0] upper_bank_ff,  upper_bank_in;
   logic       rom_mode_ff,    rom_mode_in;
   logic [6:0] rom_bank_ff,    rom_bank_in;
   logic [1:0] ram_bank_ff,    ram_bank_in;
   logic       recompute;
   logic [4:0] low_eff;
   logic [7:0] rom_mask;
   logic [1:0] sel;

   always_ff @(posedge clock) begin
      if (reset) begin
         has_ram_ff        <= 1'b0;
         rom_count_log2_ff <= 3'd1;
         ram_count_ff      <= 3'd1;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            cbc_pkg::CSR_HAS_RAM:        has_ram_ff        <= csr_write_data[0];
            cbc_pkg::CSR_ROM_COUNT_LOG2: rom_count_log2_ff <= csr_write_data;
            cbc_pkg::CSR_RAM_COUNT:      ram_count_ff      <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      ram_enable_in = ram_enable_ff;
      lower_bank_in = lower_bank_ff;
      upper_bank_in = upper_bank_ff;
      rom_mode_in   = rom_mode_ff;
      ram_bank_in   = ram_bank_ff;
      recompute     = 1'b0;
      sel           = access.data[1:0];
      if (update && access.is_write) begin
         unique case (access.address[15:13])
            cbc_pkg::RGN_RAM_ENABLE:
               ram_enable_in = (access.data[3:0] == cbc_pkg::RAM_ENABLE_KEY);
            cbc_pkg::RGN_LOWER_BANK: begin
               lower_bank_in = access.data[4:0];
               recompute     = 1'b1;
            end
            cbc_pkg::RGN_UPPER_BANK: begin
               if (rom_mode_ff) begin
                  upper_bank_in = sel;
                  recompute     = 1'b1;
               end else if ({1'b0, sel} < ram_count_ff) begin
                  ram_bank_in = sel;
               end
            end
            cbc_pkg::RGN_MODE:
               rom_mode_in = ~access.data[0];
            default: ;
         endcase
      end
      // A lower bank of zero selects bank one; the bank count then masks it.
      low_eff     = (lower_bank_in == 5'd0) ? 5'd1 : lower_bank_in;
      rom_mask    = (8'd1 << rom_count_log2_ff) - 8'd1;
      rom_bank_in = recompute ? ({upper_bank_in, low_eff} & rom_mask[6:0]) : rom_bank_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ram_enable_ff <= 1'b0;
         lower_bank_ff <= 5'd0;
         upper_bank_ff <= 2'd0;
         rom_mode_ff   <= 1'b1;
         rom_bank_ff   <= 7'd1;
         ram_bank_ff   <= 2'd0;
      end else begin
         ram_enable_ff <= ram_enable_in;
         lower_bank_ff <= lower_bank_in;
         upper_bank_ff <= upper_bank_in;
         rom_mode_ff   <= rom_mode_in;
         rom_bank_ff   <= rom_bank_in;
         ram_bank_ff   <= ram_bank_in;
      end
   end

   assign state.has_ram    = has_ram_ff;
   assign state.ram_enable = ram_enable_ff;
   assign state.rom_bank   = rom_bank_ff;
   assign state.ram_bank   = ram_bank_ff;

endmodule

`default_nettype wire

FILE: sv/cbc_decode.sv
// ----------------------------------------------------------------------------
// cbc_decode
// Maps one bus access to a ROM or RAM address, a RAM write, or a target code.
// ----------------------------------------------------------------------------
`default_nettype none

module cbc_decode (
   input  wire cbc_pkg::cbc_access_type access,
   input  wire cbc_pkg::cbc_state_type  state,
   output cbc_pkg::cbc_result_type      result
);

   logic        ram_ok;
   logic [20:0] ram_addr;

   assign ram_ok   = state.has_ram && state.ram_enable;
   assign ram_addr = {6'd0, state.ram_bank, access.address[12:0]};

   always_comb begin
      result.target           = cbc_pkg::TGT_REG_WRITE;
      result.physical_address = 21'd0;
      result.ram_write_data   = 8'd0;
      if (access.is_write) begin
         if (access.address[15:13] == cbc_pkg::RGN_EXT_RAM && ram_ok) begin
            result.target           = cbc_pkg::TGT_RAM_WRITE;
            result.physical_address = ram_addr;
            result.ram_write_data   = access.data;
         end
      end else begin
         priority if (access.address[15:14] == 2'b00) begin
            result.target           = cbc_pkg::TGT_ROM_READ;
            result.physical_address = {5'd0, access.address};
         end else if (access.address[15:14] == 2'b01) begin
            result.target           = cbc_pkg::TGT_ROM_READ;
            result.physical_address = {state.rom_bank, access.address[13:0]};
         end else if (access.address[15:13] == cbc_pkg::RGN_EXT_RAM) begin
            if (ram_ok) begin
               result.target           = cbc_pkg::TGT_RAM_READ;
               result.physical_address = ram_addr;
            end else begin
               result.target = cbc_pkg::TGT_OPEN_BUS;
            end
         end else begin
            result.target = cbc_pkg::TGT_INVALID;
         end
      end
   end

endmodule

`default_nettype wire

FILE: sv/cartridge_rom_ram_bank_controller.sv
// ----------------------------------------------------------------------------
// cartridge_rom_ram_bank_controller
// Bank controller for a cartridge with banked ROM and optional external RAM.
//
// Each bus access item gives exactly one result item. An item is taken into
// an input register, decoded against the current bank registers and placed
// in a result register, so the block sustains one item per cycle while the
// result side does not stall. An item leaves the input register only when
// the result register is free or being emptied. Register writes on the bus
// update the bank state as their item moves to the result register, so every
// later item sees them. The configuration registers are to be written only
// while no item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module cartridge_rom_ram_bank_controller (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [2:0]  csr_write_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_type,
   input  wire logic [15:0] req_bus_address,
   input  wire logic [7:0]  req_write_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_target,
   output logic [20:0]      rsp_physical_address,
   output logic [7:0]       rsp_ram_write_data
);

   logic                    in_valid_ff;
   cbc_pkg::cbc_access_type in_access_ff;
   logic                    out_valid_ff;
   cbc_pkg::cbc_result_type out_result_ff;
   cbc_pkg::cbc_state_type  state;
   cbc_pkg::cbc_result_type result;
   logic                    advance;
   logic                    req_take;

   // The input register moves on whenever the result register is free or
   // being emptied in the same cycle.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_access_ff.is_write <= req_type;
         in_access_ff.address  <= req_bus_address;
         in_access_ff.data     <= req_write_byte;
      end
   end

   cbc_bank_regs u_bank_regs (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .update           (advance),
      .access           (in_access_ff),
      .state            (state)
   );

   cbc_decode u_decode (
      .access (in_access_ff),
      .state  (state),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_result_ff <= result;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_target           = out_result_ff.target;
   assign rsp_physical_address = out_result_ff.physical_address;
   assign rsp_ram_write_data   = out_result_ff.ram_write_data;

endmodule

`default_nettype wire

FILE: tb/tb_cartridge_rom_ram_bank_controller.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cartridge_rom_ram_bank_controller
// Self-checking bench for the cartridge bank controller. A table of directed
// bus accesses and register writes is walked first. Random phases follow,
// each with its own register setting. Every accepted access is run through
// a local model of the bank registers, and its translation (or the table's
// result) is queued. Each result item is checked field by field against the
// oldest queued one. Both handshakes idle at random except in the last phase.
// ----------------------------------------------------------------------------

module tb_cartridge_rom_ram_bank_controller;

   localparam int DRAIN_CYCLES   = 4;
   localparam int ITEMS_PER_PASS = 90;
   localparam int RANDOM_PASSES  = 6;
   localparam int MAX_PRINTED    = 100;

   typedef enum logic {ROW_ACCESS, ROW_CSR} stim_kind_type;

   typedef struct packed {
      stim_kind_type           kind;
      logic                    is_write;
      logic [15:0]             addr;
      logic [7:0]              data;
      logic                    fixed;
      cbc_pkg::cbc_result_type res;
      logic [1:0]              csr_idx;
      logic [2:0]              csr_val;
   } stim_row_type;

   logic        clock                = 1'b0;
   logic        reset                = 1'b1;
   logic        csr_write_enable     = 1'b0;
   logic [1:0]  csr_index            = '0;
   logic [2:0]  csr_write_data       = '0;
   logic        req_valid            = 1'b0;
   logic        req_stall;
   logic        req_type             = 1'b0;
   logic [15:0] req_bus_address      = '0;
   logic [7:0]  req_write_byte       = '0;
   logic        rsp_valid;
   logic        rsp_stall            = 1'b0;
   logic [2:0]  rsp_target;
   logic [20:0] rsp_physical_address;
   logic [7:0]  rsp_ram_write_data;

   // Expectation typed into the table, travelling alongside the payload.
   logic                    exp_fixed_on  = 1'b0;
   cbc_pkg::cbc_result_type exp_fixed_res = '0;

   // Local copy of the configuration and of the bank registers.
   logic       cfg_has_ram     = 1'b0;
   logic [2:0] cfg_rom_log2    = 3'd1;
   logic [2:0] cfg_ram_count   = 3'd1;
   logic       bank_ram_enable = 1'b0;
   logic [4:0] bank_lower      = '0;
   logic [1:0] bank_upper      = '0;
   logic       bank_rom_mode   = 1'b1;
   logic [6:0] bank_rom        = 7'd1;
   logic [1:0] bank_ram        = '0;

   cbc_pkg::cbc_result_type pending_results[$];
   stim_row_type            stim_table[$];

   logic idle_on        = 1'b1;
   int   stall_left     = 0;
   int   quiet_left     = 0;
   int   errors_found   = 0;
   int   items_accepted = 0;
   int   results_seen   = 0;
   int   target_seen [0:5];

   cartridge_rom_ram_bank_controller DUT (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_type             (req_type),
      .req_bus_address      (req_bus_address),
      .req_write_byte       (req_write_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_target           (rsp_target),
      .rsp_physical_address (rsp_physical_address),
      .rsp_ram_write_data   (rsp_ram_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // A lower bank of zero reads as one; the result is cut to the ROM size.
   function automatic logic [6:0] masked_rom_bank();
      logic [4:0] low;
      logic [7:0] mask;
      low  = (bank_lower == 5'd0) ? 5'd1 : bank_lower;
      mask = (8'd1 << cfg_rom_log2) - 8'd1;
      return {bank_upper, low} & mask[6:0];
   endfunction

   function automatic cbc_pkg::cbc_result_type translate_access(
         input logic is_write, input logic [15:0] addr, input logic [7:0] data);
      cbc_pkg::cbc_result_type res;
      logic                    ram_ok;
      logic [1:0]              sel;
      res    = '0;
      ram_ok = cfg_has_ram && bank_ram_enable;
      sel    = data[1:0];
      if (is_write) begin
         res.target = cbc_pkg::TGT_REG_WRITE;
         unique case (addr[15:13])
            cbc_pkg::RGN_RAM_ENABLE:
               bank_ram_enable = (data[3:0] == cbc_pkg::RAM_ENABLE_KEY);
            cbc_pkg::RGN_LOWER_BANK: begin
               bank_lower = data[4:0];
               bank_rom   = masked_rom_bank();
            end
            cbc_pkg::RGN_UPPER_BANK: begin
               if (bank_rom_mode) begin
                  bank_upper = sel;
                  bank_rom   = masked_rom_bank();
               end else if ({1'b0, sel} < cfg_ram_count) begin
                  bank_ram = sel;
               end
            end
            cbc_pkg::RGN_MODE: bank_rom_mode = ~data[0];
            cbc_pkg::RGN_EXT_RAM: begin
               if (ram_ok) begin
                  res.target           = cbc_pkg::TGT_RAM_WRITE;
                  res.physical_address = {6'd0, bank_ram, addr[12:0]};
                  res.ram_write_data   = data;
               end
            end
            default: ;
         endcase
      end else if (!addr[15]) begin
         res.target = cbc_pkg::TGT_ROM_READ;
         if (!addr[14])
            res.physical_address = {5'd0, addr};
         else
            res.physical_address = {bank_rom, addr[13:0]};
      end else if (addr[15:13] == cbc_pkg::RGN_EXT_RAM) begin
         if (ram_ok) begin
            res.target           = cbc_pkg::TGT_RAM_READ;
            res.physical_address = {6'd0, bank_ram, addr[12:0]};
         end else begin
            res.target = cbc_pkg::TGT_OPEN_BUS;
         end
      end else begin
         res.target = cbc_pkg::TGT_INVALID;
      end
      return res;
   endfunction

   task automatic report_error(input string msg);
      errors_found = errors_found + 1;
      if (errors_found <= MAX_PRINTED)
         $display("ERROR at %0t: %s", $time, msg);
   endtask

   function automatic void add_access(input logic w, input logic [15:0] a,
                                      input logic [7:0] d);
      stim_row_type row;
      row          = '0;
      row.is_write = w;
      row.addr     = a;
      row.data     = d;
      stim_table.push_back(row);
   endfunction

   function automatic void add_fixed(input logic w, input logic [15:0] a,
                                     input logic [7:0] d, input logic [2:0] tgt,
                                     input logic [20:0] phys, input logic [7:0] wdata);
      stim_row_type row;
      row                      = '0;
      row.is_write             = w;
      row.addr                 = a;
      row.data                 = d;
      row.fixed                = 1'b1;
      row.res.target           = tgt;
      row.res.physical_address = phys;
      row.res.ram_write_data   = wdata;
      stim_table.push_back(row);
   endfunction

   function automatic void add_csr(input logic [1:0] idx, input logic [2:0] val);
      stim_row_type row;
      row         = '0;
      row.kind    = ROW_CSR;
      row.csr_idx = idx;
      row.csr_val = val;
      stim_table.push_back(row);
   endfunction

   // Entered and left at a falling edge; valid stays high into the next item.
   task automatic send_access(input logic w, input logic [15:0] a, input logic [7:0] d,
                              input logic fixed, input cbc_pkg::cbc_result_type fres);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= w;
      req_bus_address <= a;
      req_write_byte  <= d;
      exp_fixed_on    <= fixed;
      exp_fixed_res   <= fres;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [2:0] val);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      unique case (idx)
         cbc_pkg::CSR_HAS_RAM:        cfg_has_ram   = val[0];
         cbc_pkg::CSR_ROM_COUNT_LOG2: cfg_rom_log2  = val;
         cbc_pkg::CSR_RAM_COUNT:      cfg_ram_count = val;
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   // Result side back-pressure: random bursts of stalls between quiet stretches.
   always @(negedge clock) begin : stall_gen
      logic next_stall;
      if (!idle_on) begin
         next_stall = 1'b0;
      end else if (stall_left > 0) begin
         next_stall = 1'b1;
         stall_left = stall_left - 1;
      end else if (quiet_left > 0) begin
         next_stall = 1'b0;
         quiet_left = quiet_left - 1;
      end else if ($urandom_range(0, 2) == 0) begin
         next_stall = 1'b1;
         stall_left = $urandom_range(0, 8);
      end else begin
         next_stall = 1'b0;
         quiet_left = $urandom_range(0, 24);
      end
      rsp_stall <= next_stall;
   end

   always @(posedge clock) begin : monitor
      cbc_pkg::cbc_result_type predicted;
      cbc_pkg::cbc_result_type expected_res;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predicted = translate_access(req_type, req_bus_address, req_write_byte);
            pending_results.push_back(exp_fixed_on ? exp_fixed_res : predicted);
            items_accepted = items_accepted + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            results_seen = results_seen + 1;
            if (pending_results.size() == 0) begin
               report_error($sformatf("result %0d arrived with nothing expected",
                                      results_seen));
            end else begin
               expected_res = pending_results.pop_front();
               if (rsp_target <= cbc_pkg::TGT_INVALID)
                  target_seen[rsp_target] = target_seen[rsp_target] + 1;
               if (rsp_target !== expected_res.target)
                  report_error($sformatf("result %0d target: got %0d, expected %0d",
                                         results_seen, rsp_target, expected_res.target));
               if (rsp_physical_address !== expected_res.physical_address)
                  report_error($sformatf("result %0d address: got %h, expected %h",
                                         results_seen, rsp_physical_address,
                                         expected_res.physical_address));
               if (rsp_ram_write_data !== expected_res.ram_write_data)
                  report_error($sformatf("result %0d write data: got %h, expected %h",
                                         results_seen, rsp_ram_write_data,
                                         expected_res.ram_write_data));
            end
         end
      end
   end

   initial begin : stimulus
      int          r;
      logic        w;
      logic [15:0] a;
      logic [7:0]  d;
      logic [2:0]  set_log2;
      logic [2:0]  set_count;
      logic        set_ram;

      foreach (target_seen[i]) target_seen[i] = 0;

      // Reset state: no RAM, two ROM banks, bank one mapped high.
      add_fixed(1'b0, 16'h0000, 8'h00, cbc_pkg::TGT_ROM_READ,  21'h000000, 8'h00);
      add_fixed(1'b0, 16'h7FFF, 8'h00, cbc_pkg::TGT_ROM_READ,  21'h007FFF, 8'h00);
      add_fixed(1'b0, 16'hA000, 8'h00, cbc_pkg::TGT_OPEN_BUS,  21'h000000, 8'h00);
      add_fixed(1'b0, 16'hFFFF, 8'h00, cbc_pkg::TGT_INVALID,   21'h000000, 8'h00);
      add_fixed(1'b1, 16'hA000, 8'hFF, cbc_pkg::TGT_REG_WRITE, 21'h000000, 8'h00);
      add_fixed(1'b1, 16'hC000, 8'h55, cbc_pkg::TGT_REG_WRITE, 21'h000000, 8'h00);
      add_csr(cbc_pkg::CSR_HAS_RAM, 3'd1);
      add_csr(cbc_pkg::CSR_ROM_COUNT_LOG2, 3'd7);
      add_csr(cbc_pkg::CSR_RAM_COUNT, 3'd4);
      add_fixed(1'b1, 16'h0000, 8'h0A, cbc_pkg::TGT_REG_WRITE, 21'h000000, 8'h00);
      add_fixed(1'b1, 16'hBFFF, 8'hFF, cbc_pkg::TGT_RAM_WRITE, 21'h001FFF, 8'hFF);
      add_fixed(1'b0, 16'hA000, 8'h00, cbc_pkg::TGT_RAM_READ,  21'h000000, 8'h00);
      add_fixed(1'b1, 16'h2000, 8'h00, cbc_pkg::TGT_REG_WRITE, 21'h000000, 8'h00);
      add_fixed(1'b1, 16'h3FFF, 8'hFF, cbc_pkg::TGT_REG_WRITE, 21'h000000, 8'h00);
      add_fixed(1'b1, 16'h4000, 8'hFF, cbc_pkg::TGT_REG_WRITE, 21'h000000, 8'h00);
      add_fixed(1'b0, 16'h7FFF, 8'h00, cbc_pkg::TGT_ROM_READ,  21'h1FFFFF, 8'h00);
      add_fixed(1'b1, 16'h6000, 8'h01, cbc_pkg::TGT_REG_WRITE, 21'h000000, 8'h00);
      add_fixed(1'b1, 16'h5FFF, 8'h03, cbc_pkg::TGT_REG_WRITE, 21'h000000, 8'h00);
      add_access(1'b1, 16'hA123, 8'h5A);
      add_fixed(1'b1, 16'h1FFF, 8'hF5, cbc_pkg::TGT_REG_WRITE, 21'h000000, 8'h00);
      add_fixed(1'b0, 16'hBFFF, 8'h00, cbc_pkg::TGT_OPEN_BUS,  21'h000000, 8'h00);
      add_fixed(1'b1, 16'h7FFF, 8'hFE, cbc_pkg::TGT_REG_WRITE, 21'h000000, 8'h00);
      // A new ROM size only bites at the next bank write; size code zero masks to bank 0.
      add_csr(cbc_pkg::CSR_ROM_COUNT_LOG2, 3'd0);
      add_access(1'b0, 16'h4000, 8'h00);
      add_fixed(1'b1, 16'h2000, 8'h05, cbc_pkg::TGT_REG_WRITE, 21'h000000, 8'h00);
      add_fixed(1'b0, 16'h4001, 8'h00, cbc_pkg::TGT_ROM_READ,  21'h000001, 8'h00);
      // With no RAM banks every RAM bank select is dropped.
      add_csr(cbc_pkg::CSR_RAM_COUNT, 3'd0);
      add_fixed(1'b1, 16'h6000, 8'h01, cbc_pkg::TGT_REG_WRITE, 21'h000000, 8'h00);
      add_fixed(1'b1, 16'h4000, 8'h00, cbc_pkg::TGT_REG_WRITE, 21'h000000, 8'h00);
      add_fixed(1'b1, 16'h0000, 8'h3A, cbc_pkg::TGT_REG_WRITE, 21'h000000, 8'h00);
      add_access(1'b0, 16'hA000, 8'h00);

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (stim_table[i]) begin
         if (stim_table[i].kind == ROW_CSR) begin
            wait_drained();
            write_csr(stim_table[i].csr_idx, stim_table[i].csr_val);
         end else begin
            send_access(stim_table[i].is_write, stim_table[i].addr, stim_table[i].data,
                        stim_table[i].fixed, stim_table[i].res);
         end
      end

      for (int pass = 0; pass < RANDOM_PASSES; pass++) begin
         wait_drained();
         unique case (pass)
            0: begin set_ram = 1'b1; set_log2 = 3'd7; set_count = 3'd4; end
            1: begin set_ram = 1'b0; set_log2 = 3'd1; set_count = 3'd1; end
            2: begin set_ram = 1'b1; set_log2 = 3'd0; set_count = 3'd0; end
            5: begin set_ram = 1'b1; set_log2 = 3'd7; set_count = 3'd7; end
            default: begin
               set_ram   = (pass == 4) ? 1'b1 : 1'($urandom_range(0, 1));
               set_log2  = 3'($urandom_range(0, 7));
               set_count = 3'($urandom_range(0, 7));
            end
         endcase
         write_csr(cbc_pkg::CSR_HAS_RAM, {2'b00, set_ram});
         write_csr(cbc_pkg::CSR_ROM_COUNT_LOG2, set_log2);
         write_csr(cbc_pkg::CSR_RAM_COUNT, set_count);
         // The closing pass runs at full rate on both sides.
         if (pass == RANDOM_PASSES - 1) idle_on = 1'b0;

         for (int k = 0; k < ITEMS_PER_PASS; k++) begin
            if (pass == 3 && k == ITEMS_PER_PASS / 2) wait_drained();
            r = $urandom_range(0, 99);
            a = 16'($urandom);
            d = 8'($urandom);
            w = 1'b1;
            if (r < 10) begin
               a[15:13] = cbc_pkg::RGN_RAM_ENABLE;
               if ($urandom_range(0, 1) == 1) d[3:0] = cbc_pkg::RAM_ENABLE_KEY;
            end else if (r < 20) begin
               a[15:13] = cbc_pkg::RGN_LOWER_BANK;
            end else if (r < 28) begin
               a[15:13] = cbc_pkg::RGN_UPPER_BANK;
            end else if (r < 34) begin
               a[15:13] = cbc_pkg::RGN_MODE;
            end else if (r < 50) begin
               a[15:13] = cbc_pkg::RGN_EXT_RAM;
            end else if (r < 66) begin
               a[15:13] = cbc_pkg::RGN_EXT_RAM;
               w        = 1'b0;
            end else if (r < 86) begin
               a[15] = 1'b0;
               w     = 1'b0;
            end else begin
               w = 1'($urandom_range(0, 1));
            end
            send_access(w, a, d, 1'b0, '0);
         end
      end

      wait_drained();

      $display("Run covered %0d bus items and %0d results over %0d register settings.",
               items_accepted, results_seen, RANDOM_PASSES + 4);
      $display("Targets: rom %0d, ram read %0d, ram write %0d, open bus %0d, reg %0d, bad %0d",
               target_seen[0], target_seen[1], target_seen[2], target_seen[3],
               target_seen[4], target_seen[5]);
      if (errors_found == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
